// ----- rtl/core/dcos_pkg.sv -----
// Shared types, constants and arithmetic helpers for the delayed coupled
// oscillator step unit. No dependencies; every other file imports this package.
package dcos_pkg;

  localparam int DEF_MAX_NODES  = 64;
  localparam int DEF_HISTORY    = 256;
  localparam int DEF_SINE_TABLE = 1024;
  localparam int CFG_IDX_W      = 3;

  localparam logic signed [36:0] D_Q      = 37'sd335544;
  localparam logic signed [36:0] TWO_ONE_Q = 37'sd33554432;
  localparam logic signed [31:0] INV_TWO_PI_Q32 = 32'sd683565276;
  localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;
  localparam logic signed [31:0] V_INIT = 32'sd16777;
  localparam logic signed [49:0] V_LO = -50'sd33554432;
  localparam logic signed [49:0] V_HI = 50'sd67108864;
  localparam logic signed [49:0] W_LO = -50'sd100663296;
  localparam logic signed [49:0] W_HI = 50'sd100663296;
  localparam logic [63:0] SIN_DIV [1:8] = '{64'd6, 64'd20, 64'd42, 64'd72,
                                             64'd110, 64'd156, 64'd210, 64'd272};

  typedef enum logic [2:0] {
    REG_TIME_STEP, REG_COUPLING_GAIN, REG_SPEED_FACTOR, REG_NOISE_SCALE, REG_NODE_COUNT
  } reg_idx_t;

  typedef enum logic [1:0] {
    OP_EDGE, OP_HIST, OP_UPDATE
  } opcode_t;

  typedef enum logic [4:0] {
    DP_NOP, DP_CLEAR, DP_LEN_MUL, DP_EDGE_WR, DP_HIST_WR, DP_NODE_RD, DP_NODE_LD,
    DP_EDGE, DP_CPL_MUL, DP_VV_MUL, DP_V3_MUL, DP_V3_SAT, DP_INNER_V, DP_D_MUL,
    DP_TS_MUL, DP_VN, DP_INNER_W, DP_WN, DP_VF, DP_WF, DP_EMIT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   capture;
  } dcos_cmd_t;

  typedef struct packed {
    logic edge_last;
    logic pipe_busy;
    logic out_free;
    logic clr_last;
  } dcos_stat_t;

  function automatic logic signed [31:0] sat32(input logic signed [49:0] x);
    if (x > 50'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (x < -50'sd2147483648) begin
      return 32'sh80000000;
    end
    return x[31:0];
  endfunction

  function automatic logic signed [31:0] clamp50(input logic signed [49:0] x,
                                                 input logic signed [49:0] lo,
                                                 input logic signed [49:0] hi);
    if (x < lo) begin
      return lo[31:0];
    end else if (x > hi) begin
      return hi[31:0];
    end
    return x[31:0];
  endfunction

  // Sine of a Q0.32 turn position, Q30 Taylor series rounded to Q8.24.
  function automatic logic signed [31:0] sin_entry(input logic [63:0] pos);
    logic [63:0] p;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic signed [63:0] acc;
    logic neg;
    p = pos;
    neg = 1'b0;
    if (p >= 64'h8000_0000) begin
      neg = 1'b1;
      p = p - 64'h8000_0000;
    end
    if (p > 64'h4000_0000) p = 64'h8000_0000 - p;
    x = (p * TWO_PI_Q30) >> 32;
    x2 = (x * x) >> 30;
    term = x;
    acc = signed'(x);
    for (int n = 1; n <= 8; n++) begin
      term = ((term * x2) >> 30) / SIN_DIV[n];
      if (n[0]) acc = acc - signed'(term);
      else acc = acc + signed'(term);
    end
    if (acc < 0) acc = 0;
    acc = (acc + 64'sd32) >>> 6;
    return 32'(neg ? -acc : acc);
  endfunction

endpackage

// ----- rtl/core/dcos_ctrl.sv -----
// Sequencing state machine of the oscillator step unit.
// Depends on dcos_pkg for the command and status structs and the opcodes.
module dcos_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic [1:0]            in_opcode,
  output logic                  in_ready,
  output dcos_pkg::dcos_cmd_t   cmd,
  input  dcos_pkg::dcos_stat_t  stat
);
  import dcos_pkg::*;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_LEN, S_EWR, S_HWR, S_NRD, S_NLD, S_EDGE, S_DRAIN, S_CPL,
    S_VV, S_V3M, S_V3S, S_INV, S_DMV, S_TSV, S_VN, S_INW, S_DMW, S_TSW, S_WN,
    S_VF, S_WF, S_EMIT
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: if (stat.clr_last) state_nxt = S_IDLE;
      S_IDLE: begin
        if (in_valid) begin
          case (opcode_t'(in_opcode))
            OP_EDGE:   state_nxt = S_LEN;
            OP_HIST:   state_nxt = S_HWR;
            OP_UPDATE: state_nxt = S_NRD;
            default:   state_nxt = S_IDLE;
          endcase
        end
      end
      S_LEN:   state_nxt = S_EWR;
      S_EWR:   state_nxt = S_IDLE;
      S_HWR:   state_nxt = S_IDLE;
      S_NRD:   state_nxt = S_NLD;
      S_NLD:   state_nxt = S_EDGE;
      S_EDGE:  if (stat.edge_last) state_nxt = S_DRAIN;
      S_DRAIN: if (!stat.pipe_busy) state_nxt = S_CPL;
      S_CPL:   state_nxt = S_VV;
      S_VV:    state_nxt = S_V3M;
      S_V3M:   state_nxt = S_V3S;
      S_V3S:   state_nxt = S_INV;
      S_INV:   state_nxt = S_DMV;
      S_DMV:   state_nxt = S_TSV;
      S_TSV:   state_nxt = S_VN;
      S_VN:    state_nxt = S_INW;
      S_INW:   state_nxt = S_DMW;
      S_DMW:   state_nxt = S_TSW;
      S_TSW:   state_nxt = S_WN;
      S_WN:    state_nxt = S_VF;
      S_VF:    state_nxt = S_WF;
      S_WF:    state_nxt = S_EMIT;
      S_EMIT:  if (stat.out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd.capture = (state_r == S_IDLE) && in_valid;
    case (state_r)
      S_CLEAR: cmd.op = DP_CLEAR;
      S_LEN:   cmd.op = DP_LEN_MUL;
      S_EWR:   cmd.op = DP_EDGE_WR;
      S_HWR:   cmd.op = DP_HIST_WR;
      S_NRD:   cmd.op = DP_NODE_RD;
      S_NLD:   cmd.op = DP_NODE_LD;
      S_EDGE:  cmd.op = DP_EDGE;
      S_CPL:   cmd.op = DP_CPL_MUL;
      S_VV:    cmd.op = DP_VV_MUL;
      S_V3M:   cmd.op = DP_V3_MUL;
      S_V3S:   cmd.op = DP_V3_SAT;
      S_INV:   cmd.op = DP_INNER_V;
      S_DMV:   cmd.op = DP_D_MUL;
      S_TSV:   cmd.op = DP_TS_MUL;
      S_VN:    cmd.op = DP_VN;
      S_INW:   cmd.op = DP_INNER_W;
      S_DMW:   cmd.op = DP_D_MUL;
      S_TSW:   cmd.op = DP_TS_MUL;
      S_WN:    cmd.op = DP_WN;
      S_VF:    cmd.op = DP_VF;
      S_WF:    cmd.op = DP_WF;
      S_EMIT:  cmd.op = stat.out_free ? DP_EMIT : DP_NOP;
      default: cmd.op = DP_NOP;
    endcase
  end

endmodule

// ----- rtl/core/dcos_datapath.sv -----
// Datapath of the oscillator step unit: memories, edge pipeline, shared multiplier.
// Depends on dcos_pkg; commanded by dcos_ctrl.
module dcos_datapath #(
  parameter int MAX_NODES  = dcos_pkg::DEF_MAX_NODES,
  parameter int HISTORY    = dcos_pkg::DEF_HISTORY,
  parameter int SINE_TABLE = dcos_pkg::DEF_SINE_TABLE
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  dcos_pkg::dcos_cmd_t            cmd,
  output dcos_pkg::dcos_stat_t           stat,
  input  logic [5:0]                     in_target_node,
  input  logic [5:0]                     in_source_node,
  input  logic signed [31:0]             in_weight,
  input  logic [31:0]                    in_length,
  input  logic [7:0]                     in_slot,
  input  logic signed [31:0]             in_v_value,
  input  logic signed [31:0]             in_w_value,
  input  logic signed [31:0]             in_noise_v,
  input  logic signed [31:0]             in_noise_w,
  input  logic                           cfg_valid,
  input  logic [dcos_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                    cfg_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [5:0]                     out_node,
  output logic signed [31:0]             out_v_out,
  output logic signed [31:0]             out_w_out,
  output logic                           out_step_done
);
  import dcos_pkg::*;

  localparam int NW  = $clog2(MAX_NODES);
  localparam int CW  = $clog2(MAX_NODES + 1);
  localparam int HW  = $clog2(HISTORY);
  localparam int HD  = HISTORY * MAX_NODES;
  localparam int WD  = MAX_NODES * MAX_NODES;
  localparam int HA  = $clog2(HD);
  localparam int WA  = $clog2(WD);
  localparam int TW  = $clog2(SINE_TABLE);
  localparam int STW = $clog2(SINE_TABLE + 1);
  localparam int CLR_DEPTH = (HD > WD) ? HD : WD;
  localparam int KW  = $clog2(CLR_DEPTH);

  logic [30:0]        ts_r;
  logic signed [31:0] gain_r;
  logic [31:0]        spd_r;
  logic [30:0]        ns_r;
  logic [6:0]         nc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ts_r   <= 31'd1677722;
      gain_r <= 32'sd16777216;
      spd_r  <= 32'd65536;
      ns_r   <= 31'd237253;
      nc_r   <= 7'd64;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_TIME_STEP:     ts_r   <= cfg_data[30:0];
        REG_COUPLING_GAIN: gain_r <= cfg_data;
        REG_SPEED_FACTOR:  spd_r  <= cfg_data;
        REG_NOISE_SCALE:   ns_r   <= cfg_data[30:0];
        REG_NODE_COUNT:    nc_r   <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  logic [CW-1:0] n_eff;
  always_comb begin
    if (nc_r == 7'd0) n_eff = CW'(1);
    else if (32'(nc_r) > MAX_NODES) n_eff = CW'(MAX_NODES);
    else n_eff = CW'(nc_r);
  end

  logic [5:0]         tgt_r, src_r;
  logic signed [31:0] wt_in_r, vv_r, wv_r, nv_r, nw_r;
  logic [31:0]        len_r;
  logic [7:0]         slot_r;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      tgt_r   <= in_target_node;
      src_r   <= in_source_node;
      wt_in_r <= in_weight;
      len_r   <= in_length;
      slot_r  <= in_slot;
      vv_r    <= in_v_value;
      wv_r    <= in_w_value;
      nv_r    <= in_noise_v;
      nw_r    <= in_noise_w;
    end
  end

  logic [NW-1:0] i_r, j_r, i_eff;
  logic [HW-1:0] t_r, nt;
  logic [CW-1:0] i_inc;
  logic          done;
  logic [KW-1:0] clr_cnt_r;

  assign i_eff = (CW'(i_r) >= n_eff) ? '0 : i_r;
  assign nt    = (t_r == HW'(HISTORY - 1)) ? '0 : t_r + HW'(1);
  assign i_inc = CW'(i_r) + CW'(1);
  assign done  = (i_inc >= n_eff);

  // Shared multiplier for the node update and the delay computation.
  logic signed [36:0] mul_a, mul_b;
  logic signed [73:0] prod_r;
  logic signed [49:0] prod_sh;
  logic signed [47:0] sum_r;
  logic signed [31:0] v_r, w_r, cpl_r, v2_r, v3_r, vn_r, wn_r, vf_r, wf_r;
  logic signed [36:0] acc_r;

  assign prod_sh = prod_r[73:24];

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      DP_LEN_MUL: begin
        mul_a = {5'b0, len_r};
        mul_b = {5'b0, spd_r};
      end
      DP_CPL_MUL: begin
        mul_a = 37'(sat32(50'(sum_r)));
        mul_b = 37'(gain_r);
      end
      DP_VV_MUL: begin
        mul_a = 37'(v_r);
        mul_b = 37'(v_r);
      end
      DP_V3_MUL: begin
        mul_a = 37'(sat32(prod_sh));
        mul_b = 37'(v_r);
      end
      DP_D_MUL: begin
        mul_a = acc_r;
        mul_b = D_Q;
      end
      DP_TS_MUL: begin
        mul_a = {6'b0, ts_r};
        mul_b = 37'(prod_sh);
      end
      DP_WN: begin
        mul_a = {6'b0, ns_r};
        mul_b = 37'(nv_r);
      end
      DP_VF: begin
        mul_a = {6'b0, ns_r};
        mul_b = 37'(nw_r);
      end
      default: ;
    endcase
  end

  // Edge pipeline.
  logic signed [31:0] sin_rom [SINE_TABLE];
  for (genvar k = 0; k < SINE_TABLE; k++) begin : g_rom
    localparam logic [63:0] TURN_POS = (64'(k) << 32) / SINE_TABLE;
    assign sin_rom[k] = sin_entry(TURN_POS);
  end

  logic [8:1]          pv_r;
  logic signed [31:0]  wp_r [2:7];
  logic [NW-1:0]       e1_j_r;
  logic signed [31:0]  wt_q;
  logic [HW-1:0]       dl_q;
  logic signed [31:0]  hv_q, hw_q;
  logic [HW:0]         s_wide;
  logic [HW-1:0]       s_slot;
  logic signed [63:0]  m1_r;
  logic [31+STW:0]     m2_r;
  logic [TW-1:0]       idx, idx_nxt;
  logic signed [31:0]  s0_r, s1_r, s0b_r;
  logic [23:0]         rem_r;
  logic signed [57:0]  m3_r;
  logic signed [32:0]  sn_r;
  logic signed [64:0]  m4_r;

  assign s_wide = (t_r >= dl_q) ? {1'b0, t_r} - {1'b0, dl_q}
                                : {1'b0, t_r} + (HW+1)'(HISTORY) - {1'b0, dl_q};
  assign s_slot = s_wide[HW-1:0];
  assign idx     = m2_r[32 +: TW];
  assign idx_nxt = (idx == TW'(SINE_TABLE - 1)) ? '0 : idx + TW'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= '0;
    end else begin
      pv_r[1] <= (cmd.op == DP_EDGE);
      pv_r[2] <= pv_r[1] && (wt_q != 32'sd0);
      pv_r[8:3] <= pv_r[7:2];
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    e1_j_r <= j_r;
    wp_r[2] <= wt_q;
    for (int k = 3; k <= 7; k++) wp_r[k] <= wp_r[k-1];
    m1_r  <= (33'(hv_q) - 33'(v_r)) * INV_TWO_PI_Q32;
    m2_r  <= (32+STW)'(m1_r[55:24]) * (32+STW)'(SINE_TABLE);
    s0_r  <= sin_rom[idx];
    s1_r  <= sin_rom[idx_nxt];
    rem_r <= m2_r[31:8];
    m3_r  <= (33'(s1_r) - 33'(s0_r)) * $signed({1'b0, rem_r});
    s0b_r <= s0_r;
    sn_r  <= 33'(s0b_r) + 33'(m3_r >>> 24);
    m4_r  <= wp_r[7] * sn_r;
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      DP_NODE_RD: sum_r <= '0;
      default: if (pv_r[8]) sum_r <= sum_r + 48'(m4_r >>> 24);
    endcase
    case (cmd.op)
      DP_NODE_LD: begin
        v_r <= hv_q;
        w_r <= hw_q;
      end
      DP_VV_MUL:  cpl_r <= sat32(prod_sh);
      DP_V3_MUL:  v2_r <= sat32(prod_sh);
      DP_V3_SAT:  v3_r <= sat32(prod_sh);
      DP_INNER_V: acc_r <= 37'(w_r) - 37'(v3_r) + 37'(v2_r) + (37'(v2_r) <<< 1)
                           + 37'(cpl_r);
      DP_VN:      vn_r <= sat32(50'(v_r) + prod_sh);
      DP_INNER_W: acc_r <= -TWO_ONE_Q - ((37'(vn_r) <<< 3) + (37'(vn_r) <<< 1))
                           - 37'(w_r);
      DP_WN:      wn_r <= sat32(50'(w_r) + prod_sh);
      DP_VF:      vf_r <= clamp50(50'(vn_r) + prod_sh, V_LO, V_HI);
      DP_WF:      wf_r <= clamp50(50'(wn_r) + prod_sh, W_LO, W_HI);
      default: ;
    endcase
  end

  // Node, edge and time counters, clearing sweep.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      i_r       <= '0;
      j_r       <= '0;
      t_r       <= '0;
      clr_cnt_r <= '0;
    end else begin
      case (cmd.op)
        DP_CLEAR:   clr_cnt_r <= clr_cnt_r + KW'(1);
        DP_NODE_RD: begin
          i_r <= i_eff;
          j_r <= '0;
        end
        DP_EDGE:    j_r <= j_r + NW'(1);
        DP_EMIT: begin
          i_r <= done ? '0 : i_r + NW'(1);
          if (done) t_r <= nt;
        end
        default: ;
      endcase
    end
  end

  // History memories.
  logic signed [31:0] hist_v_mem [HD];
  logic signed [31:0] hist_w_mem [HD];
  logic               h_we;
  logic [HA-1:0]      h_wa, h_ra;
  logic signed [31:0] h_dv, h_dw;

  always_comb begin
    h_we = 1'b0;
    h_wa = '0;
    h_dv = '0;
    h_dw = '0;
    case (cmd.op)
      DP_CLEAR: begin
        h_we = (32'(clr_cnt_r) < HD);
        h_wa = HA'(clr_cnt_r);
        h_dv = (32'(clr_cnt_r) < MAX_NODES) ? V_INIT : 32'sd0;
      end
      DP_HIST_WR: begin
        h_we = (32'(tgt_r) < MAX_NODES) && (32'(slot_r) < HISTORY);
        h_wa = HA'(slot_r) * HA'(MAX_NODES) + HA'(tgt_r);
        h_dv = vv_r;
        h_dw = wv_r;
      end
      DP_EMIT: begin
        h_we = 1'b1;
        h_wa = HA'(nt) * HA'(MAX_NODES) + HA'(i_r);
        h_dv = vf_r;
        h_dw = wf_r;
      end
      default: ;
    endcase
  end

  assign h_ra = (cmd.op == DP_NODE_RD) ? HA'(t_r) * HA'(MAX_NODES) + HA'(i_eff)
                                       : HA'(s_slot) * HA'(MAX_NODES) + HA'(e1_j_r);

  always_ff @(posedge clk) begin
    if (h_we) begin
      hist_v_mem[h_wa] <= h_dv;
      hist_w_mem[h_wa] <= h_dw;
    end
    hv_q <= hist_v_mem[h_ra];
    hw_q <= hist_w_mem[h_ra];
  end

  // Weight and delay memories.
  logic signed [31:0] wt_mem [WD];
  logic [HW-1:0]      dl_mem [WD];
  logic               e_we;
  logic [WA-1:0]      e_wa, e_ra;
  logic signed [31:0] e_dw;
  logic [HW-1:0]      e_dd;

  always_comb begin
    e_we = 1'b0;
    e_wa = '0;
    e_dw = '0;
    e_dd = '0;
    case (cmd.op)
      DP_CLEAR: begin
        e_we = (32'(clr_cnt_r) < WD);
        e_wa = WA'(clr_cnt_r);
      end
      DP_EDGE_WR: begin
        e_we = (32'(tgt_r) < MAX_NODES) && (32'(src_r) < MAX_NODES);
        e_wa = WA'(tgt_r) * WA'(MAX_NODES) + WA'(src_r);
        e_dw = wt_in_r;
        e_dd = (prod_r[63:32] > 32'(HISTORY - 1)) ? HW'(HISTORY - 1)
                                                  : HW'(prod_r[63:32]);
      end
      default: ;
    endcase
  end

  assign e_ra = WA'(i_r) * WA'(MAX_NODES) + WA'(j_r);

  always_ff @(posedge clk) begin
    if (e_we) begin
      wt_mem[e_wa] <= e_dw;
      dl_mem[e_wa] <= e_dd;
    end
    wt_q <= wt_mem[e_ra];
    dl_q <= dl_mem[e_ra];
  end

  // Result register.
  logic out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.op == DP_EMIT) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == DP_EMIT) begin
      out_node      <= 6'(i_r);
      out_v_out     <= vf_r;
      out_w_out     <= wf_r;
      out_step_done <= done;
    end
  end

  assign out_valid      = out_valid_r;
  assign stat.out_free  = !out_valid_r || out_ready;
  assign stat.pipe_busy = |pv_r;
  assign stat.edge_last = (CW'(j_r) + CW'(1)) == n_eff;
  assign stat.clr_last  = (clr_cnt_r == KW'(CLR_DEPTH - 1));

endmodule

// ----- rtl/core/delayed_coupled_oscillator_step_unit.sv -----
// Top level of the delayed coupled oscillator step unit.
// Depends on dcos_pkg, dcos_ctrl and dcos_datapath.
//
// Items arrive on the in_ channel (valid/ready): opcode 0 loads an edge weight
// and delay, opcode 1 writes one history entry, opcode 2 updates the next node
// and returns one transaction on the out_ channel; opcode 3 is dropped.
// Registers are written on the cfg_ channel, which is always ready.
// An edge load multiplies the length by the speed factor and then writes the edge;
// a history write is a single step. A node update holds the input while it reads
// the node, streams the incoming edges one per cycle through an 8-stage sine
// pipeline and lets it drain; then 14 steps, several on the shared multiplier,
// finish the Euler update and the emit step writes the result.
// After reset a clearing sweep over every history, weight and delay address
// initializes the memories; in_ready stays low during it.
// The result sits in an output register; the next item is accepted while it
// waits. If a second update finishes while the receiver still stalls, the
// unit holds in its last step until the register frees.
module delayed_coupled_oscillator_step_unit #(
  parameter int MAX_NODES  = dcos_pkg::DEF_MAX_NODES,
  parameter int HISTORY    = dcos_pkg::DEF_HISTORY,
  parameter int SINE_TABLE = dcos_pkg::DEF_SINE_TABLE
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [1:0]                     in_opcode,
  input  logic [5:0]                     in_target_node,
  input  logic [5:0]                     in_source_node,
  input  logic signed [31:0]             in_weight,
  input  logic [31:0]                    in_length,
  input  logic [7:0]                     in_slot,
  input  logic signed [31:0]             in_v_value,
  input  logic signed [31:0]             in_w_value,
  input  logic signed [31:0]             in_noise_v,
  input  logic signed [31:0]             in_noise_w,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [dcos_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                    cfg_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [5:0]                     out_node,
  output logic signed [31:0]             out_v_out,
  output logic signed [31:0]             out_w_out,
  output logic                           out_step_done
);
  import dcos_pkg::*;

  dcos_cmd_t  cmd;
  dcos_stat_t stat;

  assign cfg_ready = 1'b1;

  dcos_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_opcode (in_opcode),
    .in_ready  (in_ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  dcos_datapath #(
    .MAX_NODES  (MAX_NODES),
    .HISTORY    (HISTORY),
    .SINE_TABLE (SINE_TABLE)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .in_target_node (in_target_node),
    .in_source_node (in_source_node),
    .in_weight      (in_weight),
    .in_length      (in_length),
    .in_slot        (in_slot),
    .in_v_value     (in_v_value),
    .in_w_value     (in_w_value),
    .in_noise_v     (in_noise_v),
    .in_noise_w     (in_noise_w),
    .cfg_valid      (cfg_valid),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_node       (out_node),
    .out_v_out      (out_v_out),
    .out_w_out      (out_w_out),
    .out_step_done  (out_step_done)
  );

  a_idle_pipe_empty: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !stat.pipe_busy)
    else $error("Edge pipeline busy while the unit is idle.");

  a_edge_fills_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == DP_EDGE |=> stat.pipe_busy)
    else $error("Issued edge did not enter the pipeline.");

  a_emit_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == DP_EMIT |=> out_valid)
    else $error("Result was written without being presented.");

endmodule

// ----- sim/testbench.sv -----
// Self-checking testbench for delayed_coupled_oscillator_step_unit.
// It needs dcos_pkg and the unit's RTL. Its own bit-exact model of the oscillator network
// predicts every result, under directed and random traffic with random stalls.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import dcos_pkg::*;

  localparam int NODES = 64;
  localparam int SLOTS = 256;
  localparam int TAB = 1024;
  localparam int LIMIT = 1000000;
  localparam int SETTLE = 150;
  localparam logic [1:0] OP_RESERVED = 2'd3;
  localparam logic [31:0] Q_MAX = 32'h7fffffff;
  localparam logic [31:0] Q_MIN = 32'h80000000;
  localparam longint Q_ONE = 64'sd16777216;

  typedef struct {
    logic [1:0]  op;
    logic [5:0]  tgt;
    logic [5:0]  src;
    logic [31:0] weight;
    logic [31:0] length;
    logic [7:0]  slot;
    logic [31:0] v;
    logic [31:0] w;
    logic [31:0] nv;
    logic [31:0] nw;
    bit          typed;
    logic [31:0] typed_v;
  } osc_item_t;

  typedef struct {
    logic [5:0]  node;
    logic [31:0] v;
    logic [31:0] w;
    logic        done;
  } node_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] in_opcode = '0;
  logic [5:0] in_target_node = '0;
  logic [5:0] in_source_node = '0;
  logic signed [31:0] in_weight = '0;
  logic [31:0] in_length = '0;
  logic [7:0] in_slot = '0;
  logic signed [31:0] in_v_value = '0;
  logic signed [31:0] in_w_value = '0;
  logic signed [31:0] in_noise_v = '0;
  logic signed [31:0] in_noise_w = '0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [5:0] out_node;
  logic signed [31:0] out_v_out;
  logic signed [31:0] out_w_out;
  logic out_step_done;

  always #6 clk = ~clk;

  delayed_coupled_oscillator_step_unit u_top (.*);

  longint sine_rom [TAB];
  int hist_v [SLOTS][NODES];
  int hist_w [SLOTS][NODES];
  int edge_weight [NODES*NODES];
  int edge_delay [NODES*NODES];
  int cur_node;
  int cur_slot;
  longint dt_q;
  longint gain_q;
  longint speed_q;
  longint noise_q;
  int count_q;

  node_result_t expected_updates[$];
  int mismatches = 0;
  int cycles = 0;
  bit no_idle = 1'b0;
  bit hold_trigger = 1'b0;
  int hold_left = 0;

  function automatic longint sat_q(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  function automatic longint clip_q(longint x, longint lo, longint hi);
    return x < lo ? lo : (x > hi ? hi : x);
  endfunction

  function automatic int active_nodes();
    if (count_q == 0) return 1;
    return count_q > NODES ? NODES : count_q;
  endfunction

  function automatic void build_sine_rom();
    longint unsigned p, x, x2, term;
    longint acc;
    bit neg;
    for (int k = 0; k < TAB; k++) begin
      p = (longint'(k) << 32) / TAB;
      neg = 1'b0;
      if (p >= 64'h8000_0000) begin
        neg = 1'b1;
        p -= 64'h8000_0000;
      end
      if (p > 64'h4000_0000) p = 64'h8000_0000 - p;
      x = (p * 64'd6746518852) >> 32;
      x2 = (x * x) >> 30;
      term = x;
      acc = longint'(x);
      for (int n = 1; n <= 8; n++) begin
        term = ((term * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
        if (n % 2 == 1) acc -= longint'(term);
        else acc += longint'(term);
      end
      if (acc < 0) acc = 0;
      acc = (acc + 32) >>> 6;
      sine_rom[k] = neg ? -acc : acc;
    end
  endfunction

  function automatic longint phase_sine(longint ang);
    longint unsigned turn, pos;
    longint s0, s1, rem;
    int idx, nxt;
    turn = longint'(ang * 64'sd683565276);
    turn = (turn & 64'h00FF_FFFF_FFFF_FFFF) >> 24;
    pos = turn * TAB;
    idx = int'(pos >> 32);
    nxt = (idx + 1 >= TAB) ? 0 : idx + 1;
    s0 = sine_rom[idx];
    s1 = sine_rom[nxt];
    rem = longint'((pos & 64'hFFFF_FFFF) >> 8);
    return s0 + (((s1 - s0) * rem) >>> 24);
  endfunction

  function automatic void network_reset();
    for (int s = 0; s < SLOTS; s++) begin
      for (int n = 0; n < NODES; n++) begin
        hist_v[s][n] = (s == 0) ? 16777 : 0;
        hist_w[s][n] = 0;
      end
    end
    for (int e = 0; e < NODES * NODES; e++) begin
      edge_weight[e] = 0;
      edge_delay[e] = 0;
    end
    cur_node = 0;
    cur_slot = 0;
    dt_q = 1677722;
    gain_q = 16777216;
    speed_q = 65536;
    noise_q = 237253;
    count_q = 64;
  endfunction

  function automatic void network_apply(osc_item_t it);
    int n, i, t, nt, slot_j;
    longint vv, ww, sum, cpl, v2, v3, inner, vn, wn, vf, wf;
    longint unsigned d;
    node_result_t r;
    case (it.op)
      OP_EDGE: begin
        d = (longint'(it.length) * longint'(speed_q[31:0])) >> 32;
        if (d > SLOTS - 1) d = SLOTS - 1;
        edge_weight[it.tgt * NODES + it.src] = int'(it.weight);
        edge_delay[it.tgt * NODES + it.src] = int'(d);
      end
      OP_HIST: begin
        hist_v[it.slot][it.tgt] = int'(it.v);
        hist_w[it.slot][it.tgt] = int'(it.w);
      end
      OP_UPDATE: begin
        n = active_nodes();
        if (cur_node >= n) cur_node = 0;
        i = cur_node;
        t = cur_slot;
        vv = hist_v[t][i];
        ww = hist_w[t][i];
        sum = 0;
        for (int j = 0; j < n; j++) begin
          if (edge_weight[i * NODES + j] != 0) begin
            slot_j = (t + SLOTS - edge_delay[i * NODES + j]) % SLOTS;
            sum += (longint'(edge_weight[i * NODES + j]) *
                    phase_sine(longint'(hist_v[slot_j][j]) - vv)) >>> 24;
          end
        end
        cpl = sat_q((sat_q(sum) * gain_q) >>> 24);
        v2 = sat_q((vv * vv) >>> 24);
        v3 = sat_q((v2 * vv) >>> 24);
        inner = ww - v3 + 3 * v2 + cpl;
        vn = sat_q(vv + ((dt_q * ((inner * 335544) >>> 24)) >>> 24));
        inner = -2 * Q_ONE - 10 * vn - ww;
        wn = sat_q(ww + ((dt_q * ((inner * 335544) >>> 24)) >>> 24));
        vf = clip_q(vn + ((noise_q * longint'(signed'(it.nv))) >>> 24),
                    -64'sd33554432, 64'sd67108864);
        wf = clip_q(wn + ((noise_q * longint'(signed'(it.nw))) >>> 24),
                    -64'sd100663296, 64'sd100663296);
        nt = (t + 1) % SLOTS;
        hist_v[nt][i] = int'(vf);
        hist_w[nt][i] = int'(wf);
        cur_node = i + 1;
        r.done = cur_node >= n;
        if (r.done) begin
          cur_node = 0;
          cur_slot = nt;
        end
        r.node = i[5:0];
        r.v = it.typed ? it.typed_v : vf[31:0];
        r.w = wf[31:0];
        expected_updates.push_back(r);
      end
      default: ;
    endcase
  endfunction

  task automatic offer_item(osc_item_t it);
    if (!no_idle && $urandom_range(99) < 30) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_opcode <= it.op;
    in_target_node <= it.tgt;
    in_source_node <= it.src;
    in_weight <= it.weight;
    in_length <= it.length;
    in_slot <= it.slot;
    in_v_value <= it.v;
    in_w_value <= it.w;
    in_noise_v <= it.nv;
    in_noise_w <= it.nw;
    do @(posedge clk); while (!in_ready);
    network_apply(it);
  endtask

  task automatic drain_updates();
    in_valid <= 1'b0;
    while (expected_updates.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_TIME_STEP: dt_q = longint'(data[30:0]);
      REG_COUPLING_GAIN: gain_q = longint'(signed'(data));
      REG_SPEED_FACTOR: speed_q = longint'(data);
      REG_NOISE_SCALE: noise_q = longint'(data[30:0]);
      REG_NODE_COUNT: count_q = int'(data[6:0]);
      default: ;
    endcase
    @(posedge clk);
  endtask

  function automatic logic [31:0] rand_q(int lo, int hi);
    return 32'($urandom_range(0, hi - lo)) + 32'(lo);
  endfunction

  function automatic osc_item_t random_item();
    osc_item_t it;
    int pick;
    pick = $urandom_range(99);
    it.op = pick < 25 ? OP_EDGE : pick < 45 ? OP_HIST : pick < 95 ? OP_UPDATE : OP_RESERVED;
    it.tgt = ($urandom_range(1) != 0) ? 6'($urandom_range(0, active_nodes() - 1))
                                      : 6'($urandom);
    it.src = ($urandom_range(1) != 0) ? 6'($urandom_range(0, active_nodes() - 1))
                                      : 6'($urandom);
    it.weight = ($urandom_range(9) == 0) ? $urandom : rand_q(-33554432, 33554432);
    it.length = ($urandom_range(9) == 0) ? $urandom : $urandom_range(0, 32'd1310720);
    it.slot = 8'($urandom);
    it.v = ($urandom_range(9) == 0) ? $urandom : rand_q(-33554432, 67108864);
    it.w = ($urandom_range(9) == 0) ? $urandom : rand_q(-100663296, 100663296);
    it.nv = ($urandom_range(9) == 0) ? $urandom : rand_q(-50331648, 50331648);
    it.nw = ($urandom_range(9) == 0) ? $urandom : rand_q(-50331648, 50331648);
    it.typed = 1'b0;
    it.typed_v = '0;
    return it;
  endfunction

  function automatic osc_item_t row(logic [1:0] op, logic [5:0] tgt, logic [5:0] src,
                                    logic [31:0] weight, logic [31:0] length,
                                    logic [7:0] slot, logic [31:0] v, logic [31:0] w,
                                    logic [31:0] nv, logic [31:0] nw,
                                    bit typed, logic [31:0] typed_v);
    osc_item_t it;
    it = '{op, tgt, src, weight, length, slot, v, w, nv, nw, typed, typed_v};
    return it;
  endfunction

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (hold_trigger) begin
      hold_trigger = 1'b0;
      hold_left = 600;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= no_idle || ($urandom_range(99) >= 30);
    end
  end

  always @(posedge clk) begin
    node_result_t exp_r;
    if (rst_n && out_valid && out_ready) begin
      if (expected_updates.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected transaction: node %0d", out_node);
      end else begin
        exp_r = expected_updates.pop_front();
        if (out_node !== exp_r.node || out_v_out !== exp_r.v || out_w_out !== exp_r.w ||
            out_step_done !== exp_r.done) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch: expected node %0d v %h w %h done %b, got %0d %h %h %b",
                     exp_r.node, exp_r.v, exp_r.w, exp_r.done,
                     out_node, out_v_out, out_w_out, out_step_done);
        end
      end
    end
  end

  initial begin
    osc_item_t directed [$];
    int per_phase;
    build_sine_rom();
    network_reset();
    directed = '{
      row(OP_UPDATE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0),
      row(OP_RESERVED, 6'h3f, 6'h3f, '1, '1, '1, '1, '1, '1, '1, 0, 0),
      row(OP_EDGE, 1, 63, Q_MAX, '1, 0, 0, 0, 0, 0, 0, 0),
      row(OP_EDGE, 1, 0, Q_MIN, 0, 0, 0, 0, 0, 0, 0, 0),
      row(OP_EDGE, 1, 2, 0, 32'h10000, 0, 0, 0, 0, 0, 0, 0),
      row(OP_EDGE, 63, 63, 32'h1000000, 32'h30000, 0, 0, 0, 0, 0, 0, 0),
      row(OP_HIST, 1, 0, 0, 0, 0, Q_MAX, 0, 0, 0, 0, 0),
      row(OP_HIST, 63, 0, 0, 0, 255, Q_MIN, Q_MAX, 0, 0, 0, 0),
      row(OP_HIST, 2, 0, 0, 0, 0, 0, Q_MIN, 0, 0, 0, 0),
      row(OP_UPDATE, 0, 0, 0, 0, 0, 0, 0, Q_MAX, Q_MAX, 1, 32'd67108864),
      row(OP_UPDATE, 0, 0, 0, 0, 0, 0, 0, Q_MIN, Q_MIN, 0, 0),
      row(OP_UPDATE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0)
    };
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (directed[k]) offer_item(directed[k]);
    per_phase = 106;
    for (int phase = 0; phase < 6; phase++) begin
      drain_updates();
      case (phase)
        0: write_reg(REG_NODE_COUNT, 4);
        1: begin
          write_reg(REG_TIME_STEP, 32'h7fffffff);
          write_reg(REG_COUPLING_GAIN, Q_MAX);
          write_reg(REG_SPEED_FACTOR, '1);
          write_reg(REG_NOISE_SCALE, 32'h7fffffff);
          write_reg(REG_NODE_COUNT, 0);
        end
        2: begin
          write_reg(REG_TIME_STEP, 0);
          write_reg(REG_COUPLING_GAIN, Q_MIN);
          write_reg(REG_SPEED_FACTOR, 0);
          write_reg(REG_NOISE_SCALE, 0);
          write_reg(REG_NODE_COUNT, 127);
        end
        3: begin
          write_reg(REG_TIME_STEP, $urandom_range(0, 4000000));
          write_reg(REG_COUPLING_GAIN, rand_q(-33554432, 33554432));
          write_reg(REG_SPEED_FACTOR, $urandom_range(0, 32'h80000));
          write_reg(REG_NOISE_SCALE, $urandom_range(0, 1000000));
          write_reg(REG_NODE_COUNT, $urandom_range(3, 8));
        end
        4: write_reg(REG_NODE_COUNT, 2);
        default: begin
          write_reg(REG_TIME_STEP, $urandom);
          write_reg(REG_COUPLING_GAIN, $urandom);
          write_reg(REG_SPEED_FACTOR, $urandom);
          write_reg(REG_NOISE_SCALE, $urandom);
          write_reg(REG_NODE_COUNT, $urandom_range(1, 64));
        end
      endcase
      no_idle = (phase == 2);
      for (int k = 0; k < per_phase; k++) begin
        if (phase == 1 && k == 20) hold_trigger = 1'b1;
        offer_item(random_item());
      end
    end
    no_idle = 1'b0;
    drain_updates();
    if (mismatches == 0 && expected_updates.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
